### design/pid_position_delta_clamped_assert.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Clocked assertion wrappers shared by the controller RTL.
// ----------------------------------------------------------------------------
`ifndef PID_POSITION_DELTA_CLAMPED_ASSERT_SVH
`define PID_POSITION_DELTA_CLAMPED_ASSERT_SVH

// check outside reset
`define PIDPDC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check on every edge, reset included
`define PIDPDC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### design/pidpdc_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Register map, mode codes, configuration struct and clamp helpers.
// ----------------------------------------------------------------------------
package pidpdc_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 31;
   localparam int GAIN_WIDTH      = 16;
   localparam int LIMIT_WIDTH     = 31;
   localparam int DRIVE_WIDTH     = 32;
   localparam int CLAMP_WIDTH     = 64;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MODE_SELECT    = 3'd0,
      CSR_GAIN_P         = 3'd1,
      CSR_GAIN_I         = 3'd2,
      CSR_GAIN_D         = 3'd3,
      CSR_OUTPUT_LIMIT   = 3'd4,
      CSR_INTEGRAL_LIMIT = 3'd5
   } csr_index_type;

   localparam logic MODE_POSITIONAL  = 1'b0;
   localparam logic MODE_INCREMENTAL = 1'b1;
   localparam logic ACTION_STEP      = 1'b0;
   localparam logic ACTION_CLEAR     = 1'b1;

   typedef struct packed {
      logic                          mode_select;
      logic signed [GAIN_WIDTH-1:0]  gain_p;
      logic signed [GAIN_WIDTH-1:0]  gain_i;
      logic signed [GAIN_WIDTH-1:0]  gain_d;
      logic [LIMIT_WIDTH-1:0]        output_limit;
      logic [LIMIT_WIDTH-1:0]        integral_limit;
   } cfg_type;

   // symmetric clamp to +/-lim
   function automatic logic signed [DRIVE_WIDTH-1:0] clamp_sym(
      input logic signed [CLAMP_WIDTH-1:0] x,
      input logic [LIMIT_WIDTH-1:0]        lim
   );
      logic signed [CLAMP_WIDTH-1:0] lim_s;
      logic signed [CLAMP_WIDTH-1:0] res;
      lim_s = $signed({{(CLAMP_WIDTH-LIMIT_WIDTH){1'b0}}, lim});
      if (x > lim_s) begin
         res = lim_s;
      end else if (x < -lim_s) begin
         res = -lim_s;
      end else begin
         res = x;
      end
      return res[DRIVE_WIDTH-1:0];
   endfunction

   // saturate to the 32-bit signed range
   function automatic logic signed [DRIVE_WIDTH-1:0] sat32(
      input logic signed [CLAMP_WIDTH-1:0] x
   );
      logic signed [CLAMP_WIDTH-1:0] hi;
      logic signed [CLAMP_WIDTH-1:0] lo;
      logic signed [CLAMP_WIDTH-1:0] res;
      hi = CLAMP_WIDTH'(64'sh0000_0000_7FFF_FFFF);
      lo = -hi - CLAMP_WIDTH'(64'sd1);
      if (x > hi) begin
         res = hi;
      end else if (x < lo) begin
         res = lo;
      end else begin
         res = x;
      end
      return res[DRIVE_WIDTH-1:0];
   endfunction

endpackage

### design/pidpdc_if.sv
// ----------------------------------------------------------------------------
// PID controller channels
// Request channel (action and samples) and response channel (drive value).
// ----------------------------------------------------------------------------
interface pidpdc_req_if #(
   parameter int SAMPLE_WIDTH = 16
);
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic signed [SAMPLE_WIDTH-1:0] setpoint;
   logic signed [SAMPLE_WIDTH-1:0] measured;

   modport source (output valid, action, setpoint, measured, input ready);
   modport sink   (input valid, action, setpoint, measured, output ready);
endinterface

interface pidpdc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] drive;

   modport source (output valid, drive, input ready);
   modport sink   (input valid, drive, output ready);
endinterface

### design/pidpdc_core.sv
// ----------------------------------------------------------------------------
// PID controller core
// Controller state and the single-pass positional / incremental update.
// ----------------------------------------------------------------------------
module pidpdc_core
   import pidpdc_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cfg_type                          cfg,
   input  logic                             step_fire,
   input  logic                             step_clear,
   input  logic signed [SAMPLE_WIDTH:0]     step_error,
   output logic signed [DRIVE_WIDTH-1:0]    drive_in
);

   localparam int EW   = SAMPLE_WIDTH + 1;
   localparam int D1W  = EW + 1;
   localparam int D2W  = EW + 2;
   localparam int PW   = GAIN_WIDTH + D2W;
   localparam int SUMW = PW + 3;

   logic signed [EW-1:0]          err_last_ff, err_last_in;
   logic signed [EW-1:0]          err_prev_ff, err_prev_in;
   logic signed [DRIVE_WIDTH-1:0] integ_ff, integ_in;
   logic signed [DRIVE_WIDTH-1:0] held_ff;

   logic signed [D1W-1:0]  d1;
   logic signed [D2W-1:0]  d2;
   logic signed [D2W-1:0]  op_p;
   logic signed [D2W-1:0]  op_d;
   logic signed [PW-1:0]   mul_p;
   logic signed [PW-1:0]   mul_i;
   logic signed [PW-1:0]   mul_d;
   logic signed [SUMW-1:0] integ_sum;
   logic signed [SUMW-1:0] out_sum;
   logic signed [DRIVE_WIDTH-1:0] integ_step;

   assign d1 = D1W'(step_error) - D1W'(err_last_ff);
   assign d2 = D2W'(step_error) - (D2W'(err_last_ff) <<< 1) + D2W'(err_prev_ff);

   assign op_p = (cfg.mode_select == MODE_POSITIONAL) ? D2W'(step_error) : D2W'(d1);
   assign op_d = (cfg.mode_select == MODE_POSITIONAL) ? D2W'(d1) : d2;

   assign mul_p = PW'(cfg.gain_p) * PW'(op_p);
   assign mul_i = PW'(cfg.gain_i) * PW'(step_error);
   assign mul_d = PW'(cfg.gain_d) * PW'(op_d);

   always_comb begin
      integ_sum  = SUMW'(integ_ff) + SUMW'(mul_i);
      integ_step = '0;
      out_sum    = '0;
      drive_in   = '0;
      if (cfg.mode_select == MODE_POSITIONAL) begin
         integ_step = clamp_sym(CLAMP_WIDTH'(integ_sum), cfg.integral_limit);
         out_sum    = SUMW'(mul_p) + SUMW'(integ_step) + SUMW'(mul_d);
      end else begin
         integ_step = sat32(CLAMP_WIDTH'(mul_i));
         out_sum    = SUMW'(held_ff) + SUMW'(mul_p) + SUMW'(mul_i) + SUMW'(mul_d);
      end
      drive_in = clamp_sym(CLAMP_WIDTH'(out_sum), cfg.output_limit);
      if (step_clear == ACTION_CLEAR) begin
         drive_in = '0;
      end
   end

   always_comb begin
      err_last_in = step_error;
      err_prev_in = err_last_ff;
      integ_in    = integ_step;
      if (step_clear == ACTION_CLEAR) begin
         err_last_in = '0;
         err_prev_in = '0;
         integ_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_last_ff <= '0;
         err_prev_ff <= '0;
         integ_ff    <= '0;
         held_ff     <= '0;
      end else if (step_fire) begin
         err_last_ff <= err_last_in;
         err_prev_ff <= err_prev_in;
         integ_ff    <= integ_in;
         held_ff     <= drive_in;
      end
   end

endmodule

### design/pid_position_delta_clamped.sv
// ----------------------------------------------------------------------------
// PID controller, positional and incremental, with clamping
// Top level: register port, input stage, controller core, output stage.
// ----------------------------------------------------------------------------
// Usage:
//   Write the six registers through csr_* while the block is idle: mode,
//   gains Kp/Ki/Kd (signed Q8.8), output and integral limits (Q.8).
//   Each req beat carries an action and a setpoint/measured pair; action
//   clear zeroes the controller state and answers with a drive of 0,
//   action step runs one control update and answers with the drive value.
//   Exactly one rsp beat follows every req beat, in order.
//   The error is formed in the input stage; the full update runs from there
//   into the output register. Throughput: one beat per cycle while rsp is
//   not stalled, set by the single update path of subtract, three
//   multiplies, adds and clamps.
//   A stalled rsp holds its beat; the input stage keeps taking one more
//   beat, after which req ready drops until rsp is taken.
//   Reset clears registers, controller state and both stages.
// ----------------------------------------------------------------------------
`include "pid_position_delta_clamped_assert.svh"

module pid_position_delta_clamped
   import pidpdc_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   pidpdc_req_if.sink                 req_chan,
   pidpdc_rsp_if.source               rsp_chan
);

   localparam int EW = SAMPLE_WIDTH + 1;

   cfg_type cfg_ff, cfg_in;

   logic                          stage_valid_ff;
   logic                          stage_clear_ff;
   logic signed [EW-1:0]          stage_error_ff;
   logic                          rsp_valid_ff;
   logic signed [DRIVE_WIDTH-1:0] rsp_drive_ff;
   logic signed [DRIVE_WIDTH-1:0] drive_in;
   logic                          advance;
   logic                          req_take;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      case (csr_index_type'(csr_index))
         CSR_MODE_SELECT:    cfg_in.mode_select    = csr_write_data[0];
         CSR_GAIN_P:         cfg_in.gain_p         = csr_write_data[GAIN_WIDTH-1:0];
         CSR_GAIN_I:         cfg_in.gain_i         = csr_write_data[GAIN_WIDTH-1:0];
         CSR_GAIN_D:         cfg_in.gain_d         = csr_write_data[GAIN_WIDTH-1:0];
         CSR_OUTPUT_LIMIT:   cfg_in.output_limit   = csr_write_data[LIMIT_WIDTH-1:0];
         CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_write_data[LIMIT_WIDTH-1:0];
         default:            cfg_in = cfg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline control
   assign advance        = stage_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         stage_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_clear_ff <= req_chan.action;
         stage_error_ff <= EW'(req_chan.setpoint) - EW'(req_chan.measured);
      end
   end

   pidpdc_core #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .step_fire  (advance),
      .step_clear (stage_clear_ff),
      .step_error (stage_error_ff),
      .drive_in   (drive_in)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_drive_ff <= drive_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.drive = rsp_drive_ff;

   `PIDPDC_ASSERT(a_clear_gives_zero, advance && stage_clear_ff == ACTION_CLEAR |=> rsp_valid_ff && rsp_drive_ff == '0, "clear beat did not return zero drive")
   `PIDPDC_ASSERT(a_ready_when_out_free, !rsp_valid_ff |-> req_chan.ready, "input stalled with free output register")
   `PIDPDC_ASSERT(a_stage_held, stage_valid_ff && !advance |=> stage_valid_ff && $stable(stage_error_ff), "stalled input stage lost its beat")
   `PIDPDC_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid_ff && !stage_valid_ff, "pipeline not empty after reset")

endmodule
